// ----- hdl/gvd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvd_pkg: shared types and constants
// Word layouts, fixed-point widths and codes for the vergence distance block.
// ----------------------------------------------------------------------------
package gvd_pkg;

  localparam int POS_W    = 32;                 // Q16.16 position
  localparam int DIR_W    = 16;                 // Q1.15 direction
  localparam int DIFF_W   = POS_W + 1;          // origin difference
  localparam int DOTW_W   = DIFF_W + DIR_W + 2; // W.R, W.L (Q.31)
  localparam int DOTD_W   = 2 * DIR_W + 1;      // R.L, R.R, L.L (Q2.30)
  localparam int SPLIT    = DOTW_W / 2;         // low part of W dots, unsigned
  localparam int PPL_W    = SPLIT + 1 + DOTD_W;
  localparam int PPH_W    = DOTW_W - SPLIT + DOTD_W;
  localparam int NUM_W    = DOTW_W + DOTD_W;    // numerators, signed
  localparam int MAG_W    = NUM_W - 1;
  localparam int DEN_W    = 2 * (DOTD_W - 1);   // Q4.60 denominator
  localparam int MU_W     = 47;                 // mu magnitude, Q.16
  localparam int QSHIFT   = 15;
  localparam int LOW_W    = MU_W - QSHIFT;      // numerator bits fed during divide
  localparam int THR_SH   = 30;
  localparam int FRAC     = 16;
  localparam int PROD_W   = MU_W + 1 + DIR_W;   // mu * direction
  localparam int S_W      = PROD_W + 1;
  localparam int T_W      = S_W - FRAC;
  localparam int DIST_W   = 32;
  localparam int SQ_IN_W  = 2 * DIST_W;
  localparam int DIV_LAT  = MU_W + 1;
  localparam int SQRT_LAT = DIST_W;
  localparam int REG_IDX_W = 1;

  localparam logic [1:0] OUT_COMPUTED    = 2'd0;
  localparam logic [1:0] OUT_SAME_ORIGIN = 2'd1;
  localparam logic [1:0] OUT_PARALLEL    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PARALLEL_THRESHOLD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_NO_CROSSING        = 1'b1;

  localparam logic [31:0] THRESHOLD_RESET   = 32'd10737;
  localparam logic [31:0] NO_CROSSING_RESET = 32'd6553600;

  typedef struct packed {
    logic signed [POS_W-1:0] left_origin_x;
    logic signed [POS_W-1:0] left_origin_y;
    logic signed [POS_W-1:0] left_origin_z;
    logic signed [DIR_W-1:0] left_dir_x;
    logic signed [DIR_W-1:0] left_dir_y;
    logic signed [DIR_W-1:0] left_dir_z;
    logic signed [POS_W-1:0] right_origin_x;
    logic signed [POS_W-1:0] right_origin_y;
    logic signed [POS_W-1:0] right_origin_z;
    logic signed [DIR_W-1:0] right_dir_x;
    logic signed [DIR_W-1:0] right_dir_y;
    logic signed [DIR_W-1:0] right_dir_z;
  } ray_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] vergence_distance;
    logic [1:0]        outcome;
  } dist_word_t;

  // travels beside the divider
  typedef struct packed {
    logic                  valid;
    logic [1:0]            outcome;
    logic                  neg_l;
    logic                  neg_r;
    logic [2:0][DIR_W-1:0] l;
    logic [2:0][DIR_W-1:0] r;
  } side_t;

  // travels beside the square root
  typedef struct packed {
    logic       valid;
    logic [1:0] outcome;
    logic       ovf;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/gvd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvd_front: dot products, denominator and numerators
// Seven stages from the ray pair to numerator magnitudes and denominator.
// ----------------------------------------------------------------------------
module gvd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire gvd_pkg::ray_word_t         in_word,
  input  wire logic [31:0]                thr,
  output logic [gvd_pkg::MAG_W-1:0]       mag_l,
  output logic [gvd_pkg::MAG_W-1:0]       mag_r,
  output logic [gvd_pkg::DEN_W-1:0]       den,
  output gvd_pkg::side_t                  side
);
  import gvd_pkg::*;

  // S1
  side_t                     s1_side;
  logic signed [DIFF_W-1:0]  s1_w [3];
  logic signed [DIR_W-1:0]   s1_l [3];
  logic signed [DIR_W-1:0]   s1_r [3];
  // S2
  side_t                         s2_side;
  logic signed [DIFF_W+DIR_W-1:0] s2_wr [3];
  logic signed [DIFF_W+DIR_W-1:0] s2_wl [3];
  logic signed [2*DIR_W-1:0]      s2_rl [3];
  logic signed [2*DIR_W-1:0]      s2_rr [3];
  logic signed [2*DIR_W-1:0]      s2_ll [3];
  logic                           s2_same;
  // S3
  side_t                     s3_side;
  logic signed [DOTW_W-1:0]  s3_wr, s3_wl;
  logic signed [DOTD_W-1:0]  s3_rl, s3_rr, s3_ll;
  // S4
  side_t                     s4_side;
  logic [DEN_W-1:0]          s4_llrr, s4_rlrl;
  logic signed [PPL_W-1:0]   s4_a_lo, s4_b_lo, s4_c_lo, s4_d_lo;
  logic signed [PPH_W-1:0]   s4_a_hi, s4_b_hi, s4_c_hi, s4_d_hi;
  // S5
  side_t                     s5_side;
  logic [DEN_W-1:0]          s5_den;
  logic signed [NUM_W-1:0]   s5_a, s5_b, s5_c, s5_d;
  // S6
  side_t                     s6_side;
  logic [DEN_W-1:0]          s6_den;
  logic signed [NUM_W-1:0]   s6_num_l, s6_num_r;
  // S7
  side_t                     s7_side;
  logic [DEN_W-1:0]          s7_den;
  logic [MAG_W-1:0]          s7_mag_l, s7_mag_r;

  side_t                     s1_side_next, s3_side_next, s6_side_next, s7_side_next;
  logic signed [DOTW_W-SPLIT-1:0] wr_hi, wl_hi;
  logic signed [SPLIT:0]     wr_lo, wl_lo;
  logic signed [DOTD_W-1:0]  rl_abs;
  logic                      parallel;
  logic signed [NUM_W-1:0]   neg_num_l, neg_num_r;

  always_comb begin
    s1_side_next         = '0;
    s1_side_next.valid   = in_valid;
    s1_side_next.outcome = OUT_COMPUTED;
    s1_side_next.l       = {in_word.left_dir_z, in_word.left_dir_y, in_word.left_dir_x};
    s1_side_next.r       = {in_word.right_dir_z, in_word.right_dir_y, in_word.right_dir_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.valid <= 1'b0;
    end else if (en) begin
      s1_side <= s1_side_next;
    end
    if (en) begin
      s1_w[0] <= DIFF_W'(in_word.left_origin_x) - DIFF_W'(in_word.right_origin_x);
      s1_w[1] <= DIFF_W'(in_word.left_origin_y) - DIFF_W'(in_word.right_origin_y);
      s1_w[2] <= DIFF_W'(in_word.left_origin_z) - DIFF_W'(in_word.right_origin_z);
      s1_l[0] <= in_word.left_dir_x;
      s1_l[1] <= in_word.left_dir_y;
      s1_l[2] <= in_word.left_dir_z;
      s1_r[0] <= in_word.right_dir_x;
      s1_r[1] <= in_word.right_dir_y;
      s1_r[2] <= in_word.right_dir_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else if (en) begin
      s2_side <= s1_side;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_wr[k] <= s1_w[k] * s1_r[k];
        s2_wl[k] <= s1_w[k] * s1_l[k];
        s2_rl[k] <= s1_r[k] * s1_l[k];
        s2_rr[k] <= s1_r[k] * s1_r[k];
        s2_ll[k] <= s1_l[k] * s1_l[k];
      end
      s2_same <= (s1_w[0] == '0) && (s1_w[1] == '0) && (s1_w[2] == '0);
    end
  end

  always_comb begin
    s3_side_next         = s2_side;
    s3_side_next.outcome = s2_same ? OUT_SAME_ORIGIN : OUT_COMPUTED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else if (en) begin
      s3_side <= s3_side_next;
    end
    if (en) begin
      s3_wr <= DOTW_W'(s2_wr[0]) + DOTW_W'(s2_wr[1]) + DOTW_W'(s2_wr[2]);
      s3_wl <= DOTW_W'(s2_wl[0]) + DOTW_W'(s2_wl[1]) + DOTW_W'(s2_wl[2]);
      s3_rl <= DOTD_W'(s2_rl[0]) + DOTD_W'(s2_rl[1]) + DOTD_W'(s2_rl[2]);
      s3_rr <= DOTD_W'(s2_rr[0]) + DOTD_W'(s2_rr[1]) + DOTD_W'(s2_rr[2]);
      s3_ll <= DOTD_W'(s2_ll[0]) + DOTD_W'(s2_ll[1]) + DOTD_W'(s2_ll[2]);
    end
  end

  // W dots split in two so each partial product stays narrow
  assign wr_lo  = signed'({1'b0, s3_wr[SPLIT-1:0]});
  assign wl_lo  = signed'({1'b0, s3_wl[SPLIT-1:0]});
  assign wr_hi  = s3_wr[DOTW_W-1:SPLIT];
  assign wl_hi  = s3_wl[DOTW_W-1:SPLIT];
  assign rl_abs = s3_rl[DOTD_W-1] ? -s3_rl : s3_rl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_side.valid <= 1'b0;
    end else if (en) begin
      s4_side <= s3_side;
    end
    if (en) begin
      s4_llrr <= s3_ll[DOTD_W-2:0] * s3_rr[DOTD_W-2:0];
      s4_rlrl <= rl_abs[DOTD_W-2:0] * rl_abs[DOTD_W-2:0];
      s4_a_lo <= wr_lo * s3_rl;
      s4_a_hi <= wr_hi * s3_rl;
      s4_b_lo <= wl_lo * s3_rr;
      s4_b_hi <= wl_hi * s3_rr;
      s4_c_lo <= wr_lo * s3_ll;
      s4_c_hi <= wr_hi * s3_ll;
      s4_d_lo <= wl_lo * s3_rl;
      s4_d_hi <= wl_hi * s3_rl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_side.valid <= 1'b0;
    end else if (en) begin
      s5_side <= s4_side;
    end
    if (en) begin
      s5_den <= s4_llrr - s4_rlrl;
      s5_a   <= (NUM_W'(s4_a_hi) <<< SPLIT) + NUM_W'(s4_a_lo);
      s5_b   <= (NUM_W'(s4_b_hi) <<< SPLIT) + NUM_W'(s4_b_lo);
      s5_c   <= (NUM_W'(s4_c_hi) <<< SPLIT) + NUM_W'(s4_c_lo);
      s5_d   <= (NUM_W'(s4_d_hi) <<< SPLIT) + NUM_W'(s4_d_lo);
    end
  end

  assign parallel = (s5_den == '0) ||
                    (s5_den < DEN_W'({thr, {THR_SH{1'b0}}}));

  always_comb begin
    s6_side_next = s5_side;
    if (s5_side.outcome == OUT_COMPUTED && parallel) begin
      s6_side_next.outcome = OUT_PARALLEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_side.valid <= 1'b0;
    end else if (en) begin
      s6_side <= s6_side_next;
    end
    if (en) begin
      s6_den   <= s5_den;
      s6_num_l <= s5_a - s5_b;
      s6_num_r <= s5_c - s5_d;
    end
  end

  assign neg_num_l = -s6_num_l;
  assign neg_num_r = -s6_num_r;

  always_comb begin
    s7_side_next       = s6_side;
    s7_side_next.neg_l = s6_num_l[NUM_W-1];
    s7_side_next.neg_r = s6_num_r[NUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_side.valid <= 1'b0;
    end else if (en) begin
      s7_side <= s7_side_next;
    end
    if (en) begin
      s7_den   <= s6_den;
      s7_mag_l <= s6_num_l[NUM_W-1] ? neg_num_l[MAG_W-1:0] : s6_num_l[MAG_W-1:0];
      s7_mag_r <= s6_num_r[NUM_W-1] ? neg_num_r[MAG_W-1:0] : s6_num_r[MAG_W-1:0];
    end
  end

  assign mag_l = s7_mag_l;
  assign mag_r = s7_mag_r;
  assign den   = s7_den;
  assign side  = s7_side;

endmodule
`default_nettype wire

// ----- hdl/gvd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvd_div: pipelined scale divider
// |num| * 2^15 / den, one quotient bit per stage, saturated to 2^47-1.
// ----------------------------------------------------------------------------
module gvd_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [gvd_pkg::MAG_W-1:0] mag,
  input  wire logic [gvd_pkg::DEN_W-1:0] den,
  output logic [gvd_pkg::MU_W-1:0]       quo
);
  import gvd_pkg::*;

  localparam int HI_W  = MAG_W - LOW_W;
  localparam int CMP_W = HI_W > DEN_W ? HI_W : DEN_W;

  logic [DEN_W-1:0] rem   [MU_W+1];
  logic [MU_W-1:0]  sh    [MU_W+1];
  logic [DEN_W-1:0] den_q [MU_W+1];
  logic             sat   [MU_W+1];

  // quotient reaches 2^47 exactly when the upper numerator bits reach den
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0]   <= CMP_W'(mag[MAG_W-1:LOW_W]) >= CMP_W'(den);
      rem[0]   <= DEN_W'(mag[MAG_W-1:LOW_W]);
      sh[0]    <= {mag[LOW_W-1:0], {QSHIFT{1'b0}}};
      den_q[0] <= den;
    end
  end

  for (genvar i = 0; i < MU_W; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem[i], sh[i][MU_W-1]};
    assign diff  = trial - {1'b0, den_q[i]};
    assign take  = trial >= {1'b0, den_q[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]   <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        sh[i+1]    <= {sh[i][MU_W-2:0], take};
        den_q[i+1] <= den_q[i];
        sat[i+1]   <= sat[i];
      end
    end
  end

  assign quo = sat[MU_W] ? {MU_W{1'b1}} : sh[MU_W];

endmodule
`default_nettype wire

// ----- hdl/gvd_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvd_sqrt: pipelined integer square root
// floor(sqrt(x)) of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module gvd_sqrt (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [gvd_pkg::SQ_IN_W-1:0] x,
  output logic [gvd_pkg::DIST_W-1:0]       root
);
  import gvd_pkg::*;

  localparam int REM_W = DIST_W + 2;

  logic [REM_W-1:0]   rem  [DIST_W+1];
  logic [DIST_W-1:0]  rt   [DIST_W+1];
  logic [SQ_IN_W-1:0] xs   [DIST_W+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign xs[0]  = x;

  for (genvar i = 0; i < DIST_W; i++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             take;

    assign cur   = {rem[i], xs[i][SQ_IN_W-1 -: 2]};
    assign trial = (REM_W+2)'({rt[i], 2'b01});
    assign diff  = cur - trial;
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? diff[REM_W-1:0] : cur[REM_W-1:0];
        rt[i+1]  <= {rt[i][DIST_W-2:0], take};
        xs[i+1]  <= {xs[i][SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[DIST_W];

endmodule
`default_nettype wire

// ----- hdl/gaze_vergence_distance.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaze_vergence_distance: vergence distance of two gaze rays
// Closest points of the left and right gaze lines, distance from the origin
// midpoint to the closest-point midpoint, Q16.16 cm, saturating.
// ----------------------------------------------------------------------------
//  channel  | valid      | stall      | word
//  ---------+------------+------------+---------------------------
//  rays in  | ray_valid  | ray_stall  | ray_word  (ray_word_t)
//  dist out | dist_valid | dist_stall | dist_word (dist_word_t)
//  config   | cfg_write  | -          | cfg_index, cfg_data
//
//  One word per cycle unless a stalled output holds the pipeline; each word passes
//  through front, divide, scale/square, square root and the output register.
//  The whole pipeline advances together; a stalled output freezes every stage.
//  Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module gaze_vergence_distance (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          ray_valid,
  output logic                               ray_stall,
  input  wire gvd_pkg::ray_word_t            ray_word,
  output logic                               dist_valid,
  input  wire logic                          dist_stall,
  output gvd_pkg::dist_word_t                dist_word,
  input  wire logic                          cfg_write,
  input  wire logic [gvd_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import gvd_pkg::*;

  logic              en;
  logic [31:0]       parallel_threshold;
  logic [31:0]       no_crossing_distance;

  logic [MAG_W-1:0]  mag_l, mag_r;
  logic [DEN_W-1:0]  den;
  logic [MU_W-1:0]   quo_l, quo_r;
  side_t             side_d [DIV_LAT+1];

  ctrl_t                    t1_ctrl_next;
  side_t                    t1_side;
  logic signed [MU_W:0]     t1_mu_l, t1_mu_r;
  ctrl_t                    t2_ctrl, t3_ctrl, t4_ctrl, t5_ctrl, t6_ctrl;
  logic signed [PROD_W-1:0] t2_pl [3];
  logic signed [PROD_W-1:0] t2_pr [3];
  logic signed [S_W-1:0]    t3_s [3];
  logic [DIST_W-1:0]        t4_u [3];
  logic [SQ_IN_W-1:0]       t5_sq [3];
  logic [SQ_IN_W-1:0]       t6_x;
  logic [SQ_IN_W+1:0]       sum;
  logic signed [T_W-1:0]    t_val [3];
  logic [T_W-1:0]           t_mag [3];
  logic [2:0]               t_big;
  ctrl_t                    t4_ctrl_next, t6_ctrl_next;
  ctrl_t                    ctrl_d [SQRT_LAT+1];
  logic [DIST_W-1:0]        root;

  assign en        = !dist_valid || !dist_stall;
  assign ray_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_threshold   <= THRESHOLD_RESET;
      no_crossing_distance <= NO_CROSSING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PARALLEL_THRESHOLD: parallel_threshold   <= cfg_data;
        REG_NO_CROSSING:        no_crossing_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  gvd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ray_valid),
    .in_word  (ray_word),
    .thr      (parallel_threshold),
    .mag_l    (mag_l),
    .mag_r    (mag_r),
    .den      (den),
    .side     (side_d[0])
  );

  gvd_div u_div_l (.clk(clk), .en(en), .mag(mag_l), .den(den), .quo(quo_l));
  gvd_div u_div_r (.clk(clk), .en(en), .mag(mag_r), .den(den), .quo(quo_r));

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_d[i+1].valid <= 1'b0;
      end else if (en) begin
        side_d[i+1] <= side_d[i];
      end
    end
  end

  // T1: signed scale factors
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_side.valid <= 1'b0;
    end else if (en) begin
      t1_side <= side_d[DIV_LAT];
    end
    if (en) begin
      t1_mu_l <= side_d[DIV_LAT].neg_l ? -signed'({1'b0, quo_l}) : signed'({1'b0, quo_l});
      t1_mu_r <= side_d[DIV_LAT].neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
    end
  end

  always_comb begin
    t1_ctrl_next.valid   = t1_side.valid;
    t1_ctrl_next.outcome = t1_side.outcome;
    t1_ctrl_next.ovf     = 1'b0;
  end

  // T2: mu times direction
  always_ff @(posedge clk) begin
    if (rst) begin
      t2_ctrl.valid <= 1'b0;
    end else if (en) begin
      t2_ctrl <= t1_ctrl_next;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t2_pl[k] <= t1_mu_l * signed'(t1_side.l[k]);
        t2_pr[k] <= t1_mu_r * signed'(t1_side.r[k]);
      end
    end
  end

  // T3: per-axis sum
  always_ff @(posedge clk) begin
    if (rst) begin
      t3_ctrl.valid <= 1'b0;
    end else if (en) begin
      t3_ctrl <= t2_ctrl;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t3_s[k] <= S_W'(t2_pl[k]) + S_W'(t2_pr[k]);
      end
    end
  end

  // T4: halve to Q.16 with floor, magnitude, range check
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_val[k] = t3_s[k][S_W-1:FRAC];
      t_mag[k] = t_val[k][T_W-1] ? -t_val[k] : t_val[k];
      t_big[k] = |t_mag[k][T_W-1:DIST_W];
    end
    t4_ctrl_next     = t3_ctrl;
    t4_ctrl_next.ovf = |t_big;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_ctrl.valid <= 1'b0;
    end else if (en) begin
      t4_ctrl <= t4_ctrl_next;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t4_u[k] <= t_mag[k][DIST_W-1:0];
      end
    end
  end

  // T5: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      t5_ctrl.valid <= 1'b0;
    end else if (en) begin
      t5_ctrl <= t4_ctrl;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t5_sq[k] <= t4_u[k] * t4_u[k];
      end
    end
  end

  // T6: sum of squares, overflow past 64 bits saturates
  assign sum = (SQ_IN_W+2)'(t5_sq[0]) + (SQ_IN_W+2)'(t5_sq[1]) + (SQ_IN_W+2)'(t5_sq[2]);

  always_comb begin
    t6_ctrl_next     = t5_ctrl;
    t6_ctrl_next.ovf = t5_ctrl.ovf || (|sum[SQ_IN_W+1:SQ_IN_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t6_ctrl.valid <= 1'b0;
    end else if (en) begin
      t6_ctrl <= t6_ctrl_next;
    end
    if (en) begin
      t6_x <= sum[SQ_IN_W-1:0];
    end
  end

  gvd_sqrt u_sqrt (.clk(clk), .en(en), .x(t6_x), .root(root));

  assign ctrl_d[0] = t6_ctrl;

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_ctrl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_d[i+1].valid <= 1'b0;
      end else if (en) begin
        ctrl_d[i+1] <= ctrl_d[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (en) begin
      dist_valid <= ctrl_d[SQRT_LAT].valid;
    end
    if (en) begin
      dist_word.outcome <= ctrl_d[SQRT_LAT].outcome;
      unique case (ctrl_d[SQRT_LAT].outcome)
        OUT_SAME_ORIGIN: dist_word.vergence_distance <= '0;
        OUT_PARALLEL:    dist_word.vergence_distance <= no_crossing_distance;
        OUT_COMPUTED: begin
          dist_word.vergence_distance <= ctrl_d[SQRT_LAT].ovf ? {DIST_W{1'b1}} : root;
        end
        default:         dist_word.vergence_distance <= '0;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gvd_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvd_check: port-level checks
// Watches the ports of gaze_vergence_distance; bound in below.
// ----------------------------------------------------------------------------
module gvd_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          ray_stall,
  input wire logic                          dist_valid,
  input wire logic                          dist_stall,
  input wire gvd_pkg::dist_word_t           dist_word
);
  import gvd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !dist_valid)
    else $error("result word present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_stall |=> dist_valid && $stable(dist_word))
    else $error("stalled result word changed");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    ray_stall == (dist_valid && dist_stall))
    else $error("input stall does not follow output backpressure");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> (dist_word.outcome == OUT_COMPUTED ||
                    dist_word.outcome == OUT_SAME_ORIGIN ||
                    dist_word.outcome == OUT_PARALLEL))
    else $error("unused outcome code");

  a_same_zero: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_word.outcome == OUT_SAME_ORIGIN |->
      dist_word.vergence_distance == '0)
    else $error("identical origins with nonzero distance");

endmodule

bind gaze_vergence_distance gvd_check u_gvd_check (.*);
`default_nettype wire
